@@ design/ansgr_pkg.sv @@
package ansgr_pkg;

    localparam logic [7:0]  ESC_BYTE      = 8'h1b;
    localparam logic [31:0] DEFAULT_COLOR = 32'hffcccccc;
    localparam int          MAX_SEQ_LEN_D = 32;
    localparam int          QDEPTH        = 4;

    localparam logic [1:0] PH_SEEK = 2'd0;
    localparam logic [1:0] PH_KIND = 2'd1;
    localparam logic [1:0] PH_ARGS = 2'd2;
    localparam logic [1:0] PH_STOP = 2'd3;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_PAL  = 2'd1;
    localparam logic [1:0] KIND_RGB  = 2'd2;

    localparam logic [31:0] BASE16 [16] = '{
        32'hff000000, 32'hff000080, 32'hff008000, 32'hff008080,
        32'hff800000, 32'hff800080, 32'hff808000, 32'hffc0c0c0,
        32'hff808080, 32'hff0000ff, 32'hff00ff00, 32'hff00ffff,
        32'hffff0000, 32'hffff00ff, 32'hffffff00, 32'hffffffff
    };

    localparam logic [31:0] FIXED8 [8] = '{
        32'hffcccccc, 32'hff7a77f2, 32'hff99cc99, 32'hff66ccff,
        32'hffcc9966, 32'hffcc99cc, 32'hffcccc66, 32'hff2d2d2d
    };

    typedef struct packed {
        logic [31:0] color;
        logic        held;
        logic        inseq;
        logic [7:0]  slen;
        logic [7:0]  cfirst;
        logic [1:0]  phase;
        logic [1:0]  flen;
        logic [7:0]  ffc;
        logic [7:0]  fsc;
        logic [7:0]  cdig;
        logic [1:0]  kind;
        logic [7:0]  acc;
        logic        bad;
        logic [1:0]  acnt;
        logic [7:0]  arg0;
        logic [7:0]  arg1;
        logic [7:0]  arg2;
    } t_pstate;

    typedef struct packed {
        logic [7:0]  data;
        logic [31:0] color;
        logic        last;
    } t_res;

    typedef struct packed {
        logic v0;
        logic v1;
        t_res e0;
        t_res e1;
    } t_push;

    function automatic t_pstate f_clear_field(t_pstate s);
        t_pstate r;
        r      = s;
        r.flen = 2'd0;
        r.ffc  = 8'd0;
        r.fsc  = 8'd0;
        r.acc  = 8'd0;
        r.bad  = 1'b0;
        return r;
    endfunction

    function automatic t_pstate f_clear_parser(t_pstate s);
        t_pstate r;
        r        = f_clear_field(s);
        r.held   = 1'b0;
        r.inseq  = 1'b0;
        r.slen   = 8'd0;
        r.cfirst = 8'd0;
        r.phase  = PH_SEEK;
        r.cdig   = 8'd0;
        r.kind   = KIND_NONE;
        r.acnt   = 2'd0;
        return r;
    endfunction

    function automatic t_pstate f_field_char(t_pstate s, logic [7:0] c);
        t_pstate     r;
        logic [11:0] v;
        r = s;
        v = 12'(s.acc) * 12'd10 + 12'(c - 8'h30);
        if (s.flen == 2'd0) begin
            r.ffc = c;
        end else if (s.flen == 2'd1) begin
            r.fsc = c;
        end
        if (s.flen != 2'd3) begin
            r.flen = s.flen + 2'd1;
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            if (!s.bad) begin
                if (v > 12'd255) begin
                    r.bad = 1'b1;
                end else begin
                    r.acc = v[7:0];
                end
            end
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    function automatic t_pstate f_field_end(t_pstate s);
        t_pstate    r;
        logic [7:0] a;
        r = s;
        a = (s.flen == 2'd0 || s.bad) ? 8'd0 : s.acc;
        unique case (s.phase)
            PH_SEEK: begin
                if (s.flen == 2'd2 && s.ffc == 8'h33) begin
                    r.cdig  = s.fsc;
                    r.phase = PH_KIND;
                end
            end
            PH_KIND: begin
                if (s.flen == 2'd1 && s.ffc == 8'h35) begin
                    r.kind  = KIND_PAL;
                    r.phase = PH_ARGS;
                end else if (s.flen == 2'd1 && s.ffc == 8'h32) begin
                    r.kind  = KIND_RGB;
                    r.phase = PH_ARGS;
                end else begin
                    r.phase = PH_STOP;
                end
            end
            PH_ARGS: begin
                if (s.acnt != 2'd3) begin
                    unique case (s.acnt)
                        2'd0:    r.arg0 = a;
                        2'd1:    r.arg1 = a;
                        default: r.arg2 = a;
                    endcase
                    r.acnt = s.acnt + 2'd1;
                end
            end
            default: ;
        endcase
        return f_clear_field(r);
    endfunction

    function automatic logic [7:0] f_level(logic [2:0] v);
        return (v == 3'd0) ? 8'd0 : 8'd55 + 8'd40 * 8'(v);
    endfunction

    function automatic logic [31:0] f_palette(logic [7:0] idx);
        logic [7:0] n, rem, r, g, b;
        logic [2:0] qr, qg;
        n   = idx - 8'd16;
        qr  = 3'd0;
        qg  = 3'd0;
        for (int k = 1; k < 6; k++) begin
            if (n >= 8'(36 * k)) qr = 3'(k);
        end
        rem = n - 8'd36 * 8'(qr);
        for (int k = 1; k < 6; k++) begin
            if (rem >= 8'(6 * k)) qg = 3'(k);
        end
        r = f_level(qr);
        g = f_level(qg);
        b = f_level(3'(rem - 8'd6 * 8'(qg)));
        if (idx < 8'd16) begin
            return BASE16[idx[3:0]];
        end else if (idx >= 8'd232) begin
            r = 8'd8 + 8'd10 * (idx - 8'd232);
            return {8'hff, r, r, r};
        end
        return {8'hff, b, g, r};
    endfunction

    function automatic t_pstate f_apply(t_pstate s);
        t_pstate r;
        r = s;
        if (s.slen == 8'd0 || (s.slen == 8'd1 && s.cfirst == 8'h30)) begin
            r.color = DEFAULT_COLOR;
        end else if (s.phase != PH_SEEK) begin
            if (s.cdig >= 8'h30 && s.cdig <= 8'h37) begin
                r.color = FIXED8[s.cdig[2:0]];
            end else if (s.cdig == 8'h38) begin
                if (s.kind == KIND_PAL && s.acnt != 2'd0) begin
                    r.color = f_palette(s.arg0);
                end else if (s.kind == KIND_RGB && s.acnt == 2'd3) begin
                    r.color = {8'hff, s.arg2, s.arg1, s.arg0};
                end
            end
        end
        return r;
    endfunction

endpackage

@@ design/ansgr_parse.sv @@
module ansgr_parse import ansgr_pkg::*; #(
    parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_byte,
    input  logic        i_first,
    input  logic        i_last,
    input  logic [31:0] i_start_color,
    output t_push       o_push
);

    t_pstate r_state, n_state;

    always_comb begin
        t_pstate    s;
        logic [1:0] n;
        logic [7:0] b0, b1;
        s  = r_state;
        n  = 2'd0;
        b0 = ESC_BYTE;
        b1 = ESC_BYTE;
        if (i_first) begin
            s       = f_clear_parser(s);
            s.color = i_start_color;
        end
        if (s.held) begin
            s.held = 1'b0;
            if (i_byte == 8'h5b) begin
                s       = f_clear_parser(s);
                s.inseq = 1'b1;
            end else begin
                n = 2'd1;
                if (i_byte == ESC_BYTE) begin
                    s.held = 1'b1;
                end else begin
                    b1 = i_byte;
                    n  = 2'd2;
                end
            end
        end else if (s.inseq) begin
            if (i_byte == 8'h6d) begin
                s = f_field_end(s);
                s = f_apply(s);
                s = f_clear_parser(s);
            end else if (s.slen >= 8'(MAX_SEQ_LEN)) begin
                s = f_clear_parser(s);
            end else begin
                if (s.slen == 8'd0) s.cfirst = i_byte;
                s.slen = s.slen + 8'd1;
                if (i_byte == 8'h3b) s = f_field_end(s);
                else                 s = f_field_char(s, i_byte);
            end
        end else begin
            if (i_byte == ESC_BYTE) begin
                s.held = 1'b1;
            end else begin
                b0 = i_byte;
                n  = 2'd1;
            end
        end
        if (i_last) begin
            // flushed ESC lands after whatever this byte produced
            if (s.held) begin
                if (n == 2'd0) b0 = ESC_BYTE;
                else           b1 = ESC_BYTE;
                n = n + 2'd1;
            end
            s = f_clear_parser(s);
        end
        n_state     = s;
        o_push.v0   = i_take && (n != 2'd0);
        o_push.v1   = i_take && (n == 2'd2);
        o_push.e0   = '{data: b0, color: s.color, last: (n == 2'd1)};
        o_push.e1   = '{data: b1, color: s.color, last: 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= f_clear_parser(t_pstate'{color: DEFAULT_COLOR, default: '0});
        end else if (i_take) begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/ansgr_fifo.sv @@
module ansgr_fifo import ansgr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_room,
    output logic  o_valid,
    output t_res  o_head
);

    t_res       r_q [QDEPTH];
    t_res       n_q [QDEPTH];
    logic [2:0] r_cnt, n_cnt;

    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (i_pop && r_cnt != 3'd0) begin
            for (int i = 0; i < QDEPTH - 1; i++) n_q[i] = r_q[i + 1];
            n_cnt = n_cnt - 3'd1;
        end
        if (i_push.v0) begin
            n_q[n_cnt[1:0]] = i_push.e0;
            n_cnt = n_cnt + 3'd1;
        end
        if (i_push.v1) begin
            n_q[n_cnt[1:0]] = i_push.e1;
            n_cnt = n_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_room  = (r_cnt <= 3'd2);
    assign o_valid = (r_cnt != 3'd0);
    assign o_head  = r_q[0];

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue overfilled");
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v1 |-> i_push.v0) else $error("second request without first");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_pop) |=> o_valid) else $error("request lost");
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> o_room) else $error("push without room");

endmodule

@@ design/ansi_sgr_color_parser.sv @@
// ANSI SGR color parser.
// Slave stream carries text bytes: tdata[7:0] = in_byte, tuser = text_first,
// tlast = text_last. Master stream carries visible bytes with their color:
// tdata[7:0] = out_byte, tdata[39:8] = out_color (ABGR), tlast = run_last.
// Escape sequences ESC [ ... m are stripped and update the running color.
// The cfg channel writes start_color, the color loaded at each text_first;
// it is always ready and should only be written while the block is idle.
// The state update happens at the accept edge; the results are registered in
// a 4-deep output queue and reach the master side behind any queued entries.
// Throughput: one input request per cycle while s_tready is high, set by
// the parser state update. A byte can make two results (lone ESC plus the
// next byte), and the master side drains one per cycle while m_tready is
// high; s_tready drops while the queue holds more than two entries.
// Reset clears the parser, empties the queue and loads start_color with
// 0xffcccccc. A stalled receiver just fills the queue, then back-pressures.
module ansi_sgr_color_parser import ansgr_pkg::*; #(
    parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tuser,   // [0] text_first
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] out_byte, [39:8] out_color
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_start_color;
    logic        take;
    t_push       push;
    t_res        head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_color <= DEFAULT_COLOR;
        end else if (i_cfg_valid) begin
            r_start_color <= i_cfg_data;
        end
    end

    assign take = i_s_tvalid && o_s_tready;

    ansgr_parse #(.MAX_SEQ_LEN(MAX_SEQ_LEN)) u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_byte        (i_s_tdata),
        .i_first       (i_s_tuser),
        .i_last        (i_s_tlast),
        .i_start_color (r_start_color),
        .o_push        (push)
    );

    ansgr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_tready),
        .o_room  (o_s_tready),
        .o_valid (o_m_tvalid),
        .o_head  (head)
    );

    assign o_m_tdata = {head.color, head.data};
    assign o_m_tlast = head.last;

endmodule
